// File: src/bfec_pkg.sv
`default_nettype none

package bfec_pkg;

  // fixed field geometry
  localparam int WORD_BITS      = 32;
  localparam int COUNT_BITS     = 48;
  localparam int MAX_FRAME_BITS = 65536;

  localparam int VCNT_W  = 6;
  localparam int POP_W   = $clog2(WORD_BITS + 1);
  localparam int FACC_W  = $clog2(MAX_FRAME_BITS + 1);
  localparam int SLOT_W  = 8;
  localparam int BATCH_W = 9;
  localparam int LIMIT_W = 32;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int Q_DEPTH = 2;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [BATCH_W-1:0]    MOD_MAX = BATCH_W'(1 << SLOT_W);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ERROR_LIMIT = 4'd0,
    CFG_FRAMES_PER_BATCH  = 4'd1
  } cfg_idx_t;

  // input modes
  localparam logic MODE_COMPARE = 1'b0;
  localparam logic MODE_CLEAR   = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [WORD_BITS-1:0]  reference_bits;
    logic [WORD_BITS-1:0]  decoded_bits;
    logic [VCNT_W-1:0]     valid_count;
    logic                  frame_last;
    logic                  stop_request;
  } in_item_t;

  typedef struct packed {
    logic                   frame_had_errors;
    logic [SLOT_W-1:0]      frame_slot;
    logic [FACC_W-1:0]      frame_bit_errors;
    logic [COUNT_BITS-1:0]  total_bit_errors;
    logic [COUNT_BITS-1:0]  total_frame_errors;
    logic [COUNT_BITS-1:0]  total_frames;
    logic                   limit_reached;
  } out_item_t;

  // classified word between front and back
  typedef struct packed {
    logic              clear;
    logic              last;
    logic              stop;
    logic [POP_W-1:0]  errs;
  } fq_entry_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  frame_error_limit;
    logic [BATCH_W-1:0]  frames_per_batch;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/bit_frame_error_counter_unit.sv
// result path: a frame's closing word is taken from the queue by the back part, and its
//   result is registered once the result register is free
// throughput: one word per cycle while the queue has room and no result stalls a closing word
// reset: rst_n synchronous, active low; counters, queue and valid flags clear,
//   frame_error_limit returns to 100 and frames_per_batch to 1
`default_nettype none

module bit_frame_error_counter_unit
  import bfec_pkg::*;
#(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
  localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(1);

  cfg_t      cfg_r;
  fq_entry_t fr_entry;
  fq_entry_t q_head;
  logic      q_full;
  logic      q_valid;
  logic      q_take;
  logic      push;

  // register file: writes are always accepted, cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_error_limit <= LIMIT_RESET;
      cfg_r.frames_per_batch  <= BATCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // writes to unknown indexes are dropped
      if (cfg_index == CFG_FRAME_ERROR_LIMIT) begin
        cfg_r.frame_error_limit <= cfg_data[LIMIT_W-1:0];
      end else if (cfg_index == CFG_FRAMES_PER_BATCH) begin
        cfg_r.frames_per_batch <= cfg_data[BATCH_W-1:0];
      end
    end
  end

  // front: mask, compare and count the differing bits of each word
  bfec_front u_front (
    .item  (in_data),
    .entry (fr_entry)
  );

  // a transfer is taken whenever the queue has room, independent of the result side
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  bfec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (fr_entry),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_take),
    .pop_data  (q_head)
  );

  // back: frame accumulation, totals, slot counter and result register;
  // middle words and clears drain even while a result waits
  bfec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: src/bfec_front.sv
`default_nettype none

module bfec_front
  import bfec_pkg::*;
(
  input  in_item_t  item,
  output fq_entry_t entry
);

  logic [VCNT_W-1:0]    n_valid;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] diff;

  function automatic logic n_valid_raw_gt();
    return (32'(item.valid_count) > 32'(WORD_BITS));
  endfunction

  always_comb begin
    // counts above the word size count as a full word
    if (n_valid_raw_gt()) begin
      n_valid = VCNT_W'(WORD_BITS);
    end else begin
      n_valid = item.valid_count;
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (n_valid > VCNT_W'(i));
    end
    diff = (item.reference_bits ^ item.decoded_bits) & mask;

    entry.clear = (item.mode == MODE_CLEAR);
    entry.last  = item.frame_last;
    entry.stop  = item.stop_request;
    entry.errs  = POP_W'($countones(diff));
  end

endmodule

`default_nettype wire

// File: src/bfec_queue.sv
`default_nettype none

module bfec_queue
  import bfec_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fq_entry_t push_data,
  output logic      full,
  output logic      pop_valid,
  input  logic      pop,
  output fq_entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  fq_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/bfec_back.sv
`default_nettype none

module bfec_back
  import bfec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  fq_entry_t q_entry,
  output logic      q_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int FSUM_W = FACC_W + 1;
  localparam int TSUM_W = COUNT_BITS + 1;
  localparam int CMP_W  = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [FACC_W-1:0]     acc_r;
  logic [COUNT_BITS-1:0] bt_r, fe_r, ft_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [FSUM_W-1:0]     acc_sum;
  logic [FACC_W-1:0]     acc_new;
  logic [BATCH_W-1:0]    modv;
  logic [SLOT_W-1:0]     slot_cur, slot_nxt;
  logic [BATCH_W-1:0]    slot_inc;
  logic                  had;
  logic [TSUM_W-1:0]     bt_sum, fe_sum, ft_sum;
  logic [COUNT_BITS-1:0] bt_nxt, fe_nxt, ft_nxt;
  logic                  limit;
  logic                  out_free;
  logic                  closes;

  // an output slot is free when empty or drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign q_take   = q_valid && (q_entry.clear || !q_entry.last || out_free);
  assign closes   = q_take && !q_entry.clear && q_entry.last;

  always_comb begin
    acc_sum = {1'b0, acc_r} + FSUM_W'(q_entry.errs);
    acc_new = (acc_sum > FSUM_W'(MAX_FRAME_BITS)) ? FACC_W'(MAX_FRAME_BITS)
                                                  : acc_sum[FACC_W-1:0];

    priority if (cfg.frames_per_batch == '0) begin
      modv = BATCH_W'(1);
    end else if (cfg.frames_per_batch > MOD_MAX) begin
      modv = MOD_MAX;
    end else begin
      modv = cfg.frames_per_batch;
    end
    slot_cur = ({1'b0, slot_r} >= modv) ? '0 : slot_r;
    slot_inc = {1'b0, slot_cur} + 1'b1;
    slot_nxt = (slot_inc >= modv) ? '0 : slot_inc[SLOT_W-1:0];

    had    = (acc_new != '0);
    bt_sum = {1'b0, bt_r} + TSUM_W'(acc_new);
    fe_sum = {1'b0, fe_r} + TSUM_W'(had);
    ft_sum = {1'b0, ft_r} + TSUM_W'(1);
    bt_nxt = bt_sum[COUNT_BITS] ? CNT_MAX : bt_sum[COUNT_BITS-1:0];
    fe_nxt = fe_sum[COUNT_BITS] ? CNT_MAX : fe_sum[COUNT_BITS-1:0];
    ft_nxt = ft_sum[COUNT_BITS] ? CNT_MAX : ft_sum[COUNT_BITS-1:0];
    limit  = (CMP_W'(fe_nxt) >= CMP_W'(cfg.frame_error_limit)) || q_entry.stop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      bt_r        <= '0;
      fe_r        <= '0;
      ft_r        <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_take) begin
        if (q_entry.clear) begin
          acc_r  <= '0;
          bt_r   <= '0;
          fe_r   <= '0;
          ft_r   <= '0;
          slot_r <= '0;
        end else if (!q_entry.last) begin
          acc_r <= acc_new;
        end else begin
          acc_r  <= '0;
          bt_r   <= bt_nxt;
          fe_r   <= fe_nxt;
          ft_r   <= ft_nxt;
          slot_r <= slot_nxt;
        end
      end
      if (closes) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (closes) begin
      out_data_r.frame_had_errors   <= had;
      out_data_r.frame_slot         <= slot_cur;
      out_data_r.frame_bit_errors   <= acc_new;
      out_data_r.total_bit_errors   <= bt_nxt;
      out_data_r.total_frame_errors <= fe_nxt;
      out_data_r.total_frames       <= ft_nxt;
      out_data_r.limit_reached      <= limit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_clear_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_entry.clear |=> acc_r == '0 && slot_r == '0 && ft_r == '0 && fe_r == '0)
    else $error("counters not cleared");

  a_acc_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(acc_r) <= 32'(MAX_FRAME_BITS))
    else $error("frame accumulator past saturation");

  a_close_emits : assert property (@(posedge clk) disable iff (!rst_n)
    closes |=> out_valid_r && out_data_r.total_frames != '0)
    else $error("closed frame gave no result");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    closes |-> out_free)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/sv/bit_frame_error_counter_unit_tb.sv
`default_nettype none

module bit_frame_error_counter_unit_tb;
  import bfec_pkg::*;

  // run bounds: the slowest correct run stays far below this cycle count
  localparam int CYCLE_LIMIT     = 400000;
  // pipeline drain margin, used before register writes and at the end
  localparam int DRAIN_CYCLES    = 6;
  localparam int PHASE_WORDS     = 320;
  localparam int NUM_PHASES      = 6;
  // an index with no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'hF;

  // predicts the per-frame report from the stream of accepted words
  class error_tally;
    logic [LIMIT_W-1:0]    err_limit;
    logic [BATCH_W-1:0]    batch_len;
    int unsigned           frame_errs;
    logic [COUNT_BITS-1:0] bit_err_total;
    logic [COUNT_BITS-1:0] frame_err_total;
    logic [COUNT_BITS-1:0] frame_count;
    int unsigned           next_slot;
    out_item_t             pending_reports[$];
    int unsigned           mismatches;
    int unsigned           reports_checked;
    int unsigned           clears_seen;
    int unsigned           settings_applied;

    function new();
      err_limit        = LIMIT_W'(100);
      batch_len        = BATCH_W'(1);
      mismatches       = 0;
      reports_checked  = 0;
      clears_seen      = 0;
      settings_applied = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      frame_errs      = 0;
      bit_err_total   = '0;
      frame_err_total = '0;
      frame_count     = '0;
      next_slot       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FRAME_ERROR_LIMIT) begin
        err_limit = data[LIMIT_W-1:0];
      end else if (idx == CFG_FRAMES_PER_BATCH) begin
        batch_len = data[BATCH_W-1:0];
      end
    endfunction

    function logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] cur,
                                            logic [COUNT_BITS-1:0] add);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, cur} + {1'b0, add};
      return sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

    function void note_word(in_item_t w);
      int unsigned          nvalid;
      int unsigned          modulus;
      int unsigned          slot_now;
      logic [WORD_BITS-1:0] mask;
      out_item_t            rep;
      if (w.mode == MODE_CLEAR) begin
        clears_seen++;
        clear_counts();
        return;
      end
      nvalid = (w.valid_count > WORD_BITS) ? WORD_BITS : w.valid_count;
      mask   = (nvalid == 0) ? '0 : ({WORD_BITS{1'b1}} >> (WORD_BITS - nvalid));
      frame_errs += $countones((w.reference_bits ^ w.decoded_bits) & mask);
      if (frame_errs > MAX_FRAME_BITS) frame_errs = MAX_FRAME_BITS;
      if (!w.frame_last) return;

      modulus = (batch_len == 0) ? 1 : (batch_len > (1 << SLOT_W)) ? (1 << SLOT_W) : batch_len;
      if (next_slot >= modulus) next_slot = 0;
      slot_now  = next_slot;
      next_slot = (next_slot + 1 >= modulus) ? 0 : next_slot + 1;

      rep.frame_had_errors = (frame_errs != 0);
      rep.frame_slot       = SLOT_W'(slot_now);
      rep.frame_bit_errors = FACC_W'(frame_errs);
      if (frame_errs != 0) begin
        bit_err_total   = sat_add(bit_err_total, COUNT_BITS'(frame_errs));
        frame_err_total = sat_add(frame_err_total, COUNT_BITS'(1));
      end
      frame_count = sat_add(frame_count, COUNT_BITS'(1));
      frame_errs  = 0;
      rep.total_bit_errors   = bit_err_total;
      rep.total_frame_errors = frame_err_total;
      rep.total_frames       = frame_count;
      rep.limit_reached      = (frame_err_total >= COUNT_BITS'(err_limit)) || w.stop_request;
      pending_reports = {pending_reports, rep};
    endfunction

    function void check_field(string name, logic [COUNT_BITS-1:0] exp_v,
                              logic [COUNT_BITS-1:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t exp_r;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, expected none actual %h",
                 $time, got);
        return;
      end
      exp_r = pending_reports.pop_front();
      reports_checked++;
      check_field("frame_had_errors", exp_r.frame_had_errors, got.frame_had_errors);
      check_field("frame_slot", exp_r.frame_slot, got.frame_slot);
      check_field("frame_bit_errors", exp_r.frame_bit_errors, got.frame_bit_errors);
      check_field("total_bit_errors", exp_r.total_bit_errors, got.total_bit_errors);
      check_field("total_frame_errors", exp_r.total_frame_errors, got.total_frame_errors);
      check_field("total_frames", exp_r.total_frames, got.total_frames);
      check_field("limit_reached", exp_r.limit_reached, got.limit_reached);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  error_tally  tally;
  int unsigned words_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycles        = 0;

  bit_frame_error_counter_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10-unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bit_frame_error_counter_unit: mismatch");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle at the current rate
  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tally.check_report(out_data);
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tally.note_word(w);
    words_sent++;
  endtask

  // leaves cfg_valid high so back-to-back writes need no lowering in between
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tally.write_reg(idx, data);
  endtask

  task automatic apply_settings(logic [LIMIT_W-1:0] limit, logic [BATCH_W-1:0] batch);
    write_reg(CFG_FRAME_ERROR_LIMIT, CFG_DATA_W'(limit));
    // junk above the register width must be dropped
    write_reg(CFG_FRAMES_PER_BATCH, ($urandom() & ~CFG_DATA_W'(511)) | CFG_DATA_W'(batch));
    cfg_valid <= 1'b0;
    tally.settings_applied++;
  endtask

  // stop sending, wait for every expected report, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tally.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t cmp_word(logic [WORD_BITS-1:0] ref_w,
                                        logic [WORD_BITS-1:0] dec_w,
                                        int unsigned vcount, bit last, bit stop);
    in_item_t w;
    w.mode           = MODE_COMPARE;
    w.reference_bits = ref_w;
    w.decoded_bits   = dec_w;
    w.valid_count    = VCNT_W'(vcount);
    w.frame_last     = last;
    w.stop_request   = stop;
    return w;
  endfunction

  // clear with junk in every other field
  function automatic in_item_t clear_word();
    in_item_t w;
    w      = cmp_word($urandom(), $urandom(), $urandom_range(63),
                      $urandom_range(1), $urandom_range(1));
    w.mode = MODE_CLEAR;
    return w;
  endfunction

  // random compare word; clean words carry no bit flips at all
  function automatic in_item_t rand_word(bit clean, bit last);
    logic [WORD_BITS-1:0] flips;
    logic [WORD_BITS-1:0] ref_w;
    int unsigned          vcount;
    case ($urandom_range(3))
      0:       flips = '0;
      1:       flips = WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
      2:       flips = $urandom();
      default: flips = '1;
    endcase
    if (clean) flips = '0;
    ref_w  = $urandom();
    vcount = ($urandom_range(3) == 0) ? $urandom_range(63) : WORD_BITS;
    return cmp_word(ref_w, ref_w ^ flips, vcount, last, $urandom_range(7) == 0);
  endfunction

  task automatic send_frame(int unsigned len, bit clean);
    for (int i = 0; i < len; i++) send_item(rand_word(clean, i == len - 1));
  endtask

  // mostly whole frames, some long, some clean; a little noise and clears
  task automatic random_traffic(int unsigned quota);
    int unsigned start;
    int unsigned pick;
    start = words_sent;
    while (words_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(clear_word());
      end else if (pick < 6) begin
        send_item(rand_word($urandom_range(1), $urandom_range(1)));
      end else if (pick < 14) begin
        send_frame($urandom_range(9, 40), $urandom_range(3) == 0);
      end else begin
        send_frame($urandom_range(1, 6), $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    tally     = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset register values
    // clean single-word frame
    send_item(cmp_word('0, '0, WORD_BITS, 1'b1, 1'b0));
    // no valid bit: every flip is ignored
    send_item(cmp_word('1, '0, 0, 1'b1, 1'b0));
    // valid count above the word width counts as the full word
    send_item(cmp_word('1, '0, 63, 1'b1, 1'b0));
    // two-word frame, 33 errors in all
    send_item(cmp_word('0, '1, 33, 1'b0, 1'b0));
    send_item(cmp_word(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 1'b1, 1'b0));
    // top bit just outside, then just inside the valid range
    send_item(cmp_word(32'h8000_0000, '0, WORD_BITS - 1, 1'b1, 1'b0));
    send_item(cmp_word(32'h8000_0000, '0, WORD_BITS, 1'b1, 1'b1));
    // stop on a middle word is not remembered at the frame end
    send_item(cmp_word('1, '0, WORD_BITS, 1'b0, 1'b1));
    send_item(cmp_word('0, '0, WORD_BITS, 1'b1, 1'b0));
    // clear in the middle of a frame drops the partial count and the totals
    send_item(cmp_word('1, '0, WORD_BITS, 1'b0, 1'b0));
    send_item(clear_word());
    send_item(cmp_word('0, 32'h0000_0001, WORD_BITS, 1'b1, 1'b0));
    // middle words with random content, then a closing word
    send_item(cmp_word($urandom(), $urandom(), 17, 1'b0, 1'b0));
    send_item(cmp_word($urandom(), $urandom(), 32, 1'b0, 1'b1));
    send_item(cmp_word($urandom(), $urandom(), 5, 1'b1, 1'b1));

    // each phase: idle, new register values, then random traffic
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == 0) write_reg(CFG_SPARE_IDX, $urandom());
      case (p)
        0:       apply_settings(LIMIT_W'(3), BATCH_W'(256));
        // lower batch after a wide one, so the slot counter must wrap early
        1:       apply_settings('0, BATCH_W'(5));
        2:       apply_settings('1, '0);
        3:       apply_settings(LIMIT_W'(40), '1);
        4:       apply_settings(LIMIT_W'($urandom_range(60)), BATCH_W'(300));
        default: apply_settings(LIMIT_W'(100), BATCH_W'(1));
      endcase
      send_idle_pct = (p < 2) ? 37 : (p < 4) ? 53 : 0;
      recv_idle_pct = (p < 2) ? 53 : (p < 4) ? 37 : 0;
      random_traffic(PHASE_WORDS);
    end
    settle();

    $display("covered %0d input transfers, %0d frame reports, %0d clears, %0d register settings",
             words_sent, tally.reports_checked, tally.clears_seen, tally.settings_applied);
    $display("including out-of-range counts and batch sizes, and idling on both sides");
    if (tally.mismatches == 0) begin
      $display("bit_frame_error_counter_unit: match");
    end else begin
      $display("bit_frame_error_counter_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
